/* src/scfla_pkg.sv */
// package for the size class free list allocator
// transaction types, status codes; no dependencies
package scfla_pkg;

   localparam int ADDR_W = 20;
   localparam int SIZE_W = 11;
   localparam int REQ_W  = 16;
   localparam int STAT_W = 3;

   typedef enum logic [STAT_W-1:0] {
      STAT_GRANTED   = 3'd0,
      STAT_RELEASED  = 3'd1,
      STAT_TOO_LARGE = 3'd2,
      STAT_EXHAUSTED = 3'd3,
      STAT_LIST_FULL = 3'd4
   } status_type;

   typedef struct packed {
      logic              kind;
      logic [REQ_W-1:0]  req_size;
      logic [ADDR_W-1:0] block_addr;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] grant_addr;
      logic [SIZE_W-1:0] grant_size;
      logic [STAT_W-1:0] status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request
      logic pop;        // decrement class top, read list
      logic push;       // write block_addr on class list
      logic bump;       // bump allocate from open page
      logic carve_init; // start carving at class below request
      logic carve_load; // take the top of the carve class from the top memory
      logic carve_step; // one carve action
      logic new_page;   // open next page and allocate
      logic respond;    // emit result
      status_type stat;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic oversize;
      logic is_free;
      logic top_full;   // request class list full
      logic top_empty;  // request class list empty
      logic fits;       // rounded size fits in open page
      logic carve_done;
      logic carve_ok;   // carve class takes one more block
      logic pool_full;
   } sts_type;

endpackage

/* src/scfla_ram.sv */
// generic single port ram with registered read
// no dependencies
module scfla_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

/* src/scfla_ctrl.sv */
// controller state machine of the allocator
// depends on scfla_pkg
module scfla_ctrl import scfla_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_TOPA   = 9'b000000010,
      S_DECIDE = 9'b000000100,
      S_POPR   = 9'b000001000,
      S_CLOAD  = 9'b000010000,
      S_CFETCH = 9'b000100000,
      S_CARVE  = 9'b001000000,
      S_PAGE   = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   status_type stat_ff, stat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stat_ff  <= STAT_GRANTED;
      end else begin
         state_ff <= state_in;
         stat_ff  <= stat_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      stat_in  = stat_ff;
      cmd      = '0;
      cmd.stat = stat_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_TOPA;
            end
         end
         S_TOPA: state_in = S_DECIDE;
         S_DECIDE: begin
            if (sts.oversize) begin
               stat_in = STAT_TOO_LARGE; state_in = S_DONE;
            end else if (sts.is_free) begin
               cmd.push = !sts.top_full;
               stat_in  = sts.top_full ? STAT_LIST_FULL : STAT_RELEASED;
               state_in = S_DONE;
            end else if (!sts.top_empty) begin
               cmd.pop = 1'b1; stat_in = STAT_GRANTED; state_in = S_POPR;
            end else if (sts.fits) begin
               cmd.bump = 1'b1; stat_in = STAT_GRANTED; state_in = S_DONE;
            end else begin
               cmd.carve_init = 1'b1; state_in = S_CLOAD;
            end
         end
         S_POPR: state_in = S_DONE;
         S_CLOAD: begin
            if (sts.carve_done) state_in = S_PAGE;
            else state_in = S_CFETCH;
         end
         S_CFETCH: begin
            cmd.carve_load = 1'b1;
            state_in = S_CARVE;
         end
         S_CARVE: begin
            cmd.carve_step = 1'b1;
            if (!sts.carve_ok) state_in = S_CLOAD;
         end
         S_PAGE: begin
            if (sts.pool_full) stat_in = STAT_EXHAUSTED;
            else begin
               cmd.new_page = 1'b1; stat_in = STAT_GRANTED;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            cmd.respond = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

/* src/scfla_dp.sv */
// datapath: request registers, class top memory, page state and list memory
// depends on scfla_pkg and scfla_ram
module scfla_dp import scfla_pkg::*; #(
   parameter int GRANULE_BITS = 4,
   parameter int SMALL_LIMIT  = 1024,
   parameter int PAGE_BYTES   = 65536,
   parameter int POOL_PAGES   = 16,
   parameter int LIST_DEPTH   = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_strobe,
   output rsp_type rsp
);
   localparam int NCLASS = (SMALL_LIMIT + (1 << GRANULE_BITS) - 1) >> GRANULE_BITS;
   localparam int CW  = (NCLASS > 1) ? $clog2(NCLASS) : 1;
   localparam int SW  = $clog2(NCLASS + 1);
   localparam int TW  = $clog2(LIST_DEPTH + 1);
   localparam int EW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int LW  = $clog2(PAGE_BYTES + 1);
   localparam int PW  = $clog2(POOL_PAGES + 1);
   localparam int RW  = 17;
   localparam int MD  = NCLASS * LIST_DEPTH;
   localparam int MW  = $clog2(MD);
   localparam logic [RW-1:0] GMASK = RW'((1 << GRANULE_BITS) - 1);

   logic              kind_ff;
   logic [REQ_W-1:0]  size_raw_ff;
   logic [ADDR_W-1:0] baddr_ff;
   logic [ADDR_W-1:0] cursor_ff;
   logic [LW-1:0]     left_ff;
   logic [PW-1:0]     used_ff;
   logic [SW-1:0]     cs_ff;        // carve class, 1-based
   logic [TW-1:0]     ctop_ff;      // top of the carve class
   logic [ADDR_W-1:0] addr_ff;
   logic              pop_ff;       // list read in flight
   logic              vld_ff [NCLASS]; // class top written since reset
   logic              tv_ff;        // valid bit of the top being read

   // rounding
   logic [RW-1:0] sum_r, size_r;
   logic [SW-1:0] slot;
   logic [CW-1:0] cls, ccls;
   assign sum_r  = RW'(size_raw_ff) + GMASK;
   assign size_r = (size_raw_ff == '0) ? (GMASK + RW'(1)) : (sum_r & ~GMASK);
   assign slot   = SW'(size_r >> GRANULE_BITS);
   assign cls    = CW'(slot - SW'(1));
   assign ccls   = CW'(cs_ff - SW'(1));

   logic oversize;
   assign oversize = size_raw_ff > REQ_W'(SMALL_LIMIT);

   logic [LW-1:0] cbytes;
   assign cbytes = LW'({cs_ff, {GRANULE_BITS{1'b0}}});

   logic carve_ok;
   assign carve_ok = (cs_ff != '0) && (left_ff >= cbytes)
                     && (ctop_ff < TW'(LIST_DEPTH));

   // class top memory, unwritten tops read as zero
   logic          t_we;
   logic [CW-1:0] t_addr;
   logic [TW-1:0] t_wdata, t_rdata, top_rd;
   assign t_addr = (cs_ff != '0) ? ccls : cls;
   assign top_rd = tv_ff ? t_rdata : '0;
   always_comb begin
      t_we = 1'b0; t_wdata = ctop_ff;
      if (cmd.push) begin
         t_we = 1'b1; t_wdata = top_rd + TW'(1);
      end
      if (cmd.pop) begin
         t_we = 1'b1; t_wdata = top_rd - TW'(1);
      end
      if (cmd.carve_step && !carve_ok) t_we = 1'b1;
   end

   scfla_ram #(.WIDTH(TW), .DEPTH(NCLASS)) u_tops (
      .clock(clock), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
   );

   assign sts.oversize   = oversize;
   assign sts.is_free    = kind_ff;
   assign sts.top_full   = top_rd >= TW'(LIST_DEPTH);
   assign sts.top_empty  = top_rd == '0;
   assign sts.fits       = LW'(size_r) <= left_ff;
   assign sts.carve_done = (cs_ff == '0);
   assign sts.carve_ok   = carve_ok;
   assign sts.pool_full  = used_ff >= PW'(POOL_PAGES);

   // list memory
   logic              we;
   logic [MW-1:0]     maddr;
   logic [ADDR_W-1:0] wdata, rdata;
   logic [CW-1:0]     mcls;
   logic [EW-1:0]     ment;
   always_comb begin
      we = 1'b0; wdata = baddr_ff; mcls = cls;
      ment = EW'(top_rd);
      if (cmd.pop) ment = EW'(top_rd - TW'(1));
      if (cmd.push) we = 1'b1;
      if (cmd.carve_step) begin
         mcls = ccls; ment = EW'(ctop_ff);
         we = carve_ok; wdata = cursor_ff;
      end
   end
   assign maddr = MW'(mcls) * MW'(LIST_DEPTH) + MW'(ment);

   scfla_ram #(.WIDTH(ADDR_W), .DEPTH(MD)) u_ram (
      .clock(clock), .we(we), .addr(maddr), .wdata(wdata), .rdata(rdata)
   );

   logic [ADDR_W-1:0] pbase;
   assign pbase = ADDR_W'(used_ff * (PAGE_BYTES % (1 << ADDR_W)));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCLASS; i++) vld_ff[i] <= 1'b0;
         tv_ff <= 1'b0; pop_ff <= 1'b0; ctop_ff <= '0;
         cursor_ff <= '0; left_ff <= '0; used_ff <= '0; cs_ff <= '0;
      end else begin
         tv_ff  <= vld_ff[t_addr];
         if (t_we) vld_ff[t_addr] <= 1'b1;
         pop_ff <= cmd.pop;
         if (cmd.load) begin
            kind_ff <= req.kind; size_raw_ff <= req.req_size;
            baddr_ff <= req.block_addr;
            addr_ff <= req.kind ? req.block_addr : '0;
         end
         if (pop_ff) addr_ff <= rdata;
         if (cmd.bump) begin
            addr_ff <= cursor_ff; cursor_ff <= cursor_ff + ADDR_W'(size_r);
            left_ff <= left_ff - LW'(size_r);
         end
         if (cmd.carve_init) cs_ff <= slot - SW'(1);
         if (cmd.carve_load) ctop_ff <= top_rd;
         if (cmd.carve_step) begin
            if (carve_ok) begin
               ctop_ff   <= ctop_ff + TW'(1);
               cursor_ff <= cursor_ff + ADDR_W'(cbytes);
               left_ff   <= left_ff - cbytes;
            end else cs_ff <= cs_ff - SW'(1);
         end
         if (cmd.new_page) begin
            addr_ff   <= pbase;
            cursor_ff <= pbase + ADDR_W'(size_r);
            left_ff   <= LW'(PAGE_BYTES) - LW'(size_r);
            used_ff   <= used_ff + PW'(1);
         end
      end
   end

   assign rsp_strobe = cmd.respond;
   always_comb begin
      rsp.grant_addr = addr_ff;
      rsp.grant_size = oversize ? '0 : SIZE_W'(size_r);
      rsp.status     = cmd.stat;
   end
endmodule

/* src/size_class_free_list_allocator.sv */
// top level of the size class free list allocator
// depends on scfla_pkg, scfla_ctrl, scfla_dp, scfla_ram
//
// one transaction at a time: raise start while busy is low; exactly one
// result appears on rsp_* for one cycle with rsp_strobe high and cannot be
// stalled. states from one accepted start to the next: free, oversize and
// bump allocate pass idle, top read, decide and done; a list pop adds a
// registered ram read; a page turn walks each class below the request
// (top load, top fetch, carve steps while blocks fit), then the page state.
// no clearing pass: list entries are only read below their class top, and
// class tops carry one valid bit each so that unwritten tops read as zero.
module size_class_free_list_allocator import scfla_pkg::*; #(
   parameter int GRANULE_BITS = 4,
   parameter int SMALL_LIMIT  = 1024,
   parameter int PAGE_BYTES   = 65536,
   parameter int POOL_PAGES   = 16,
   parameter int LIST_DEPTH   = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);
   cmd_type cmd;  // controller commands
   sts_type sts;  // datapath status

   scfla_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .sts(sts), .cmd(cmd)
   );

   scfla_dp #(
      .GRANULE_BITS(GRANULE_BITS), .SMALL_LIMIT(SMALL_LIMIT),
      .PAGE_BYTES(PAGE_BYTES), .POOL_PAGES(POOL_PAGES), .LIST_DEPTH(LIST_DEPTH)
   ) u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd), .sts(sts),
      .rsp_strobe(rsp_strobe), .rsp(rsp_data)
   );
endmodule
